// ===== rtl/core/b64u_pkg.sv =====
// Shared types, constants and the character table of the base64url byte encoder.
package b64u_pkg;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // Position within the current three-byte group.
    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2
    } phase_t;

    // One queued item: up to four characters and the index of the final one.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            eom;
    } entry_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_status_t;

    // Maps a sextet onto the URL-safe alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [5:0] s;
        logic [7:0] r;
        s = v & SEXTET_MASK;
        case (s) inside
            [6'd0:6'd25]:  r = 8'(s) + 8'd65;
            [6'd26:6'd51]: r = 8'(s) + 8'd71;
            [6'd52:6'd61]: r = 8'(s) - 8'd4;
            6'd62:         r = 8'h2D;
            default:       r = 8'h5F;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/b64u_front.sv =====
// Front part: accepts message bytes, tracks the group phase and builds character items.
module b64u_front
    import b64u_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_data_byte,
    input  logic          s_end_of_message,
    input  queue_status_t q_status,
    output logic          push,
    output entry_t        push_entry
);

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_entry          = '0;
        push_entry.eom      = s_end_of_message;
        phase_next          = PHASE_0;
        carry_next          = 4'd0;
        case (phase_reg)
            PHASE_1: begin
                push_entry.chars[0] = sextet_char({carry_reg[1:0], s_data_byte[7:4]});
                if (s_end_of_message) begin
                    push_entry.chars[1] = sextet_char({s_data_byte[3:0], 2'b00});
                    push_entry.chars[2] = PAD_CHAR;
                    push_entry.last_idx = 2'd2;
                end else begin
                    push_entry.last_idx = 2'd0;
                    phase_next          = PHASE_2;
                    carry_next          = s_data_byte[3:0];
                end
            end
            PHASE_2: begin
                push_entry.chars[0] = sextet_char({carry_reg, s_data_byte[7:6]});
                push_entry.chars[1] = sextet_char(s_data_byte[5:0]);
                push_entry.last_idx = 2'd1;
            end
            default: begin
                // Start of a group; an unused phase code behaves the same way.
                push_entry.chars[0] = sextet_char(s_data_byte[7:2]);
                if (s_end_of_message) begin
                    push_entry.chars[1] = sextet_char({s_data_byte[1:0], 4'b0000});
                    push_entry.chars[2] = PAD_CHAR;
                    push_entry.chars[3] = PAD_CHAR;
                    push_entry.last_idx = 2'd3;
                end else begin
                    push_entry.last_idx = 2'd0;
                    phase_next          = PHASE_1;
                    carry_next          = {2'b00, s_data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_0;
            carry_reg <= 4'd0;
        end else if (push) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ===== rtl/core/b64u_queue.sv =====
// Short queue of character items between the front and back parts.
module b64u_queue
    import b64u_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head_entry,
    output queue_status_t status
);

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign status.full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.nonempty = (count_reg != '0);
    assign head_entry      = mem_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !status.nonempty))
        else $error("queue read while empty");

endmodule

// ===== rtl/core/b64u_back.sv =====
// Back part: takes character items from the queue and sends one character per cycle while m_ready is high.
module b64u_back
    import b64u_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_status_t q_status,
    input  entry_t        head_entry,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_char,
    output logic          m_last_char
);

    entry_t     entry_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       at_end;
    logic       xfer;

    assign xfer   = valid_reg && m_ready;
    assign at_end = (idx_reg == entry_reg.last_idx);
    assign pop    = q_status.nonempty && (!valid_reg || (xfer && at_end));

    assign m_valid     = valid_reg;
    assign m_out_char  = entry_reg.chars[idx_reg];
    assign m_last_char = entry_reg.eom && at_end;

    always_ff @(posedge aclk) begin
        if (pop) begin
            entry_reg <= head_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (xfer) begin
            if (at_end) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (idx_reg <= entry_reg.last_idx))
        else $error("character index beyond the end of its item");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |=> (valid_reg && $stable(idx_reg)))
        else $error("character moved while the receiver stalled");

endmodule

// ===== rtl/core/base64url_byte_encoder.sv =====
// Top level of the streaming base64url encoder with '=' padding.
//
// Usage: the sender offers one message byte per item on the s_ channel, with
// s_end_of_message set on the final byte of a message. The encoder returns
// ASCII characters of the URL-safe alphabet on the m_ channel, one character
// per item, most significant sextet first. After the final byte the partial
// sextet is flushed with zero bits and '=' pads follow until the message's
// character count is a multiple of four; m_last_char marks its final character.
// Both channels use valid/ready and an item moves when both are high.
// When the back part is idle, the first character of a byte passes through the
// queue and the back part's item register before it is offered. The front takes
// one byte per cycle into a two-entry queue while the queue is not full, and the
// back sends one character per cycle while the receiver is ready, so the output
// port sets the rate: one or two characters per byte inside a group, up to four
// for the final byte; four characters per three bytes sustained.
// When the receiver stalls, the current character holds and the queue fills;
// s_ready drops once the queue is full and rises again as characters drain.
// Reset (aresetn low at a clock edge) empties the queue, drops m_valid and
// returns the group phase and leftover bits to the start of a message.
module base64url_byte_encoder
    import b64u_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_char
);

    queue_status_t q_status;
    entry_t        push_entry;
    entry_t        head_entry;
    logic          push;
    logic          pop;

    // The front classifies each byte by group phase and writes the full set
    // of characters it causes into the queue as a single item.
    b64u_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_message (s_end_of_message),
        .q_status         (q_status),
        .push             (push),
        .push_entry       (push_entry)
    );

    // The queue decouples byte intake from character output.
    b64u_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    // The back steps through the characters of one queued item, one per cycle while
    // the receiver is ready, and loads the next item as the last character of the current one leaves.
    b64u_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_status    (q_status),
        .head_entry  (head_entry),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

endmodule

// ===== test/b64u_char_checker.sv =====
// Checker that predicts and compares the encoded characters of the base64url byte encoder.
module b64u_char_checker
    import b64u_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_message,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_char,
    input  logic       m_last_char,
    output int         mismatch_count,
    output int         chars_outstanding
);

    localparam logic [7:0] DASH_CHAR       = 8'h2D;
    localparam logic [7:0] UNDERSCORE_CHAR = 8'h5F;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } enc_char_t;

    enc_char_t  pending_chars[$];
    phase_t     group_pos;
    logic [3:0] leftover_bits;

    function automatic logic [7:0] url_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            return 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            return 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            return DASH_CHAR;
        end
        return UNDERSCORE_CHAR;
    endfunction

    task automatic push_char(input logic [7:0] code, input logic last);
        enc_char_t c;
        c.code = code;
        c.last = last;
        pending_chars.insert(pending_chars.size(), c);
    endtask

    // Appends the characters one byte completes and advances the group position.
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        case (group_pos)
            PHASE_1: begin
                push_char(url_char({leftover_bits[1:0], b[7:4]}), 1'b0);
                if (eom) begin
                    push_char(url_char({b[3:0], 2'b00}), 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                    group_pos     = PHASE_0;
                    leftover_bits = 4'd0;
                end else begin
                    group_pos     = PHASE_2;
                    leftover_bits = b[3:0];
                end
            end
            PHASE_2: begin
                push_char(url_char({leftover_bits, b[7:6]}), 1'b0);
                push_char(url_char(b[5:0]), eom);
                group_pos     = PHASE_0;
                leftover_bits = 4'd0;
            end
            default: begin
                push_char(url_char(b[7:2]), 1'b0);
                if (eom) begin
                    push_char(url_char({b[1:0], 4'b0000}), 1'b0);
                    push_char(PAD_CHAR, 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                    group_pos     = PHASE_0;
                    leftover_bits = 4'd0;
                end else begin
                    group_pos     = PHASE_1;
                    leftover_bits = {2'b00, b[1:0]};
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        enc_char_t want;
        if (!aresetn) begin
            pending_chars.delete();
            group_pos      = PHASE_0;
            leftover_bits  = 4'd0;
            mismatch_count = 0;
        end else begin
            // Outputs are compared before the new byte is predicted, since no
            // character can leave in the same cycle its byte is taken.
            if (m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    $error("out_char: expected none, got 0x%02h", m_out_char);
                    mismatch_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (m_out_char !== want.code) begin
                        $error("out_char: expected 0x%02h, got 0x%02h",
                               want.code, m_out_char);
                        mismatch_count++;
                    end
                    if (m_last_char !== want.last) begin
                        $error("last_char: expected %0b, got %0b", want.last, m_last_char);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                encode_byte(s_data_byte, s_end_of_message);
            end
        end
        chars_outstanding <= pending_chars.size();
    end

endmodule

// ===== test/base64url_byte_encoder_tb.sv =====
// Top of the testbench: clock, reset, byte stimulus, receiver stalls and the verdict.
module base64url_byte_encoder_tb;

    // Cycles without any accepted item before the run is declared hung. The
    // slowest legal stretch is a short random gap on either side, so this is
    // far beyond anything a correct block needs.
    localparam int HANG_LIMIT   = 2000;
    // Cycles allowed after the last expected character, for stray output.
    localparam int TAIL_CYCLES  = 10;
    // Random bytes per idling phase; with the directed bytes, four phases
    // give about 310 in all.
    localparam int PHASE_ITEMS  = 72;

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte      = 8'h00;
    logic       s_end_of_message = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [7:0] m_out_char;
    logic       m_last_char;

    int mismatch_count;
    int chars_outstanding;
    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int bytes_sent       = 0;
    int hang_cycles      = 0;

    base64url_byte_encoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_char       (m_out_char),
        .m_last_char      (m_last_char)
    );

    // The checker sees both channels exactly as the block does and keeps the
    // running count of mismatches and of characters still owed.
    b64u_char_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_message  (s_end_of_message),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_char        (m_out_char),
        .m_last_char       (m_last_char),
        .mismatch_count    (mismatch_count),
        .chars_outstanding (chars_outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver decides every cycle whether to stall. With a zero stall
    // percentage ready stays high throughout.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            hang_cycles <= 0;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
        if (hang_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one byte and returns at the clock edge that accepts it. Idle
    // cycles are inserted before the offer, so valid only drops between items
    // and never while one is waiting.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= b;
        s_end_of_message <= eom;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Sends a whole message of random bytes with the flag on the final one.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Holds the sender back until every owed character has come out. The
    // first edge is waited out because the checker's count is registered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_outstanding != 0);
    endtask

    initial begin
        int msg_len;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. One-byte messages end in the first group position
        // and get two pads, two-byte messages get one pad and three-byte
        // messages none. All-zero and all-one bytes reach both ends of the
        // alphabet, and the 0xFB 0xEF 0xBE group is all dashes.
        // Back-to-back messages check that the end of a message restarts the
        // group position.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        // The sender pauses here until the block has fully drained.
        wait_drained();

        // Random part, in four idling phases: none, a slow sender, a slow
        // receiver, and both at once. Messages are mostly short so that the
        // padded endings come often, with some longer ones for sustained runs.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            while (bytes_sent < 19 + (p + 1) * PHASE_ITEMS) begin
                if ($urandom_range(9) < 8) begin
                    msg_len = $urandom_range(6, 1);
                end else begin
                    msg_len = $urandom_range(16, 7);
                end
                send_message(msg_len);
            end
        end

        // Wait for the last characters, then give stray output time to show.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
